@@ src/serial_command_framer_core_defines.svh @@
// Assertion macros for the serial command framer.
`ifndef SERIAL_COMMAND_FRAMER_CORE_DEFINES_SVH
`define SERIAL_COMMAND_FRAMER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SCF_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("serial command framer check failed");
`define SCF_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("serial command framer check failed");
`else
`define SCF_ASSERT(label, prop)
`define SCF_ASSERT_ALWAYS(label, prop)
`endif

`endif

@@ src/scf_pkg.sv @@
// Types, constants and helpers shared by the serial command framer.
package scf_pkg;

    localparam int MAX_COMMANDS = 8;
    localparam int ACC_W        = 32;
    localparam int COUNT_W      = 4;
    localparam int SIZES_W      = 24;
    localparam int LEFT_W       = 3;
    localparam int CMD_W        = 3;

    localparam logic REG_COMMAND_COUNT = 1'b0;
    localparam logic REG_PAYLOAD_SIZES = 1'b1;

    localparam logic REQ_POLL = 1'b0;
    localparam logic REQ_SEND = 1'b1;

    typedef struct packed {
        logic              pending_valid;
        logic [7:0]        pending_low_byte;
        logic [LEFT_W-1:0] payload_left;
        logic [7:0]        current_command;
        logic [ACC_W-1:0]  payload_accumulator;
    } scf_state_t;

    typedef struct packed {
        logic               req_type;
        logic               tx_busy;
        logic               rx_available;
        logic [7:0]         rx_byte;
        logic [15:0]        send_value;
    } scf_item_t;

    typedef struct packed {
        logic               tx_valid;
        logic [7:0]         tx_byte;
        logic               dispatch_valid;
        logic [CMD_W-1:0]   dispatch_command;
        logic [ACC_W-1:0]   dispatch_data;
    } scf_result_t;

    function automatic logic [COUNT_W-1:0] known_count(input logic [COUNT_W-1:0] count);
        logic [COUNT_W-1:0] cap;
        cap = COUNT_W'(MAX_COMMANDS);
        return (count > cap) ? cap : count;
    endfunction

    function automatic logic [LEFT_W-1:0] payload_size(input logic [SIZES_W-1:0] sizes,
                                                       input logic [CMD_W-1:0] cmd);
        logic [4:0] base;
        base = 5'(cmd) * 5'd3;
        return sizes[base +: LEFT_W];
    endfunction

endpackage

@@ src/scf_step.sv @@
// Per-beat framing logic: transmit, frame parse and dispatch decision.
module scf_step
(
    input  scf_pkg::scf_state_t               state,
    input  scf_pkg::scf_item_t                item,
    input  logic [scf_pkg::COUNT_W-1:0]       command_count,
    input  logic [scf_pkg::SIZES_W-1:0]       payload_sizes,
    output scf_pkg::scf_state_t               state_next,
    output scf_pkg::scf_result_t              result,
    output logic                              has_result
);

    logic [scf_pkg::COUNT_W-1:0] known;
    logic                        rx_known;
    logic                        cmd_known;

    assign known    = scf_pkg::known_count(command_count);
    assign rx_known = item.rx_byte < 8'(known);

    always_comb
    begin
        state_next = state;
        result     = '0;
        cmd_known  = 1'b0;
        if (item.req_type == scf_pkg::REQ_SEND)
        begin
            state_next.pending_low_byte = item.send_value[7:0];
            state_next.pending_valid    = 1'b1;
            result.tx_valid             = 1'b1;
            result.tx_byte              = item.send_value[15:8];
        end
        else
        begin
            if (!item.tx_busy && state.pending_valid)
            begin
                result.tx_valid          = 1'b1;
                result.tx_byte           = state.pending_low_byte;
                state_next.pending_valid = 1'b0;
            end
            if (item.rx_available)
            begin
                if (state.payload_left == '0)
                begin
                    state_next.current_command     = item.rx_byte;
                    state_next.payload_accumulator = '0;
                    if (rx_known)
                    begin
                        state_next.payload_left =
                            scf_pkg::payload_size(payload_sizes, item.rx_byte[2:0]);
                    end
                end
                else
                begin
                    state_next.payload_accumulator =
                        {state.payload_accumulator[scf_pkg::ACC_W-9:0], item.rx_byte};
                    state_next.payload_left = state.payload_left - 1'b1;
                end
                cmd_known = state_next.current_command < 8'(known);
                if (state_next.payload_left == '0 && cmd_known)
                begin
                    result.dispatch_valid   = 1'b1;
                    result.dispatch_command = state_next.current_command[2:0];
                    result.dispatch_data    = state_next.payload_accumulator;
                end
            end
        end
    end

    assign has_result = result.tx_valid | result.dispatch_valid;

endmodule

@@ src/serial_command_framer_core.sv @@
// Serial command framer top level: config registers, framing state, output register.
// A result is registered and appears on the master side in the cycle after its input beat is taken.
// Throughput: one input beat per cycle; the only stall is a held output register.
// s_tready is low only while a result waits and m_tready is low.
// Reset (rst_n low, asynchronous): config, framing state and output valid clear to zero.
`include "serial_command_framer_core_defines.svh"

module serial_command_framer_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,  // tx_busy, rx_available, rx_byte, send_value
    input  logic                          s_tuser,  // req_type
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [47:0]                   m_tdata,  // tx_byte, dispatch_command, dispatch_data
    output logic [1:0]                    m_tuser,  // tx_valid, dispatch_valid
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [scf_pkg::SIZES_W-1:0]   cfg_data
);

    logic [scf_pkg::COUNT_W-1:0] command_count_reg;
    logic [scf_pkg::SIZES_W-1:0] payload_sizes_reg;
    scf_pkg::scf_state_t         state_reg;
    scf_pkg::scf_state_t         state_next;
    scf_pkg::scf_item_t          item;
    scf_pkg::scf_result_t        result_next;
    scf_pkg::scf_result_t        result_reg;
    logic                        has_result;
    logic                        out_valid_reg;
    logic                        in_beat;

    assign item.req_type     = s_tuser;
    assign item.tx_busy      = s_tdata[0];
    assign item.rx_available = s_tdata[1];
    assign item.rx_byte      = s_tdata[9:2];
    assign item.send_value   = s_tdata[25:10];

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_beat   = s_tvalid && s_tready;

    scf_step u_step
    (
        .state         (state_reg),
        .item          (item),
        .command_count (command_count_reg),
        .payload_sizes (payload_sizes_reg),
        .state_next    (state_next),
        .result        (result_next),
        .has_result    (has_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            command_count_reg <= '0;
            payload_sizes_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                scf_pkg::REG_COMMAND_COUNT: command_count_reg <= cfg_data[scf_pkg::COUNT_W-1:0];
                scf_pkg::REG_PAYLOAD_SIZES: payload_sizes_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (in_beat)
        begin
            state_reg     <= state_next;
            out_valid_reg <= has_result;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat && has_result)
        begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {result_reg.dispatch_valid, result_reg.tx_valid};
    assign m_tdata  = {5'b0, result_reg.dispatch_data, result_reg.dispatch_command,
                       result_reg.tx_byte};

    `SCF_ASSERT(a_result_has_kind, m_tvalid |-> (m_tuser[0] || m_tuser[1]))
    `SCF_ASSERT(a_idle_tx_zero, (m_tvalid && !m_tuser[0]) |-> (m_tdata[7:0] == 8'h00))
    `SCF_ASSERT(a_idle_dispatch_zero, (m_tvalid && !m_tuser[1]) |-> (m_tdata[42:8] == '0))
    `SCF_ASSERT(a_send_sets_pending, (in_beat && s_tuser) |=> state_reg.pending_valid)
    `SCF_ASSERT(a_send_emits_tx, (in_beat && s_tuser) |=> (m_tvalid && m_tuser[0]))
    `SCF_ASSERT_ALWAYS(a_ready_when_empty, !m_tvalid |-> s_tready)

endmodule
